// File: rtl/core/mac_pair_flow_byte_aggregator_defines.svh
// assertion macros for the flow byte aggregator
`ifndef MAC_PAIR_FLOW_BYTE_AGGREGATOR_DEFINES_SVH
`define MAC_PAIR_FLOW_BYTE_AGGREGATOR_DEFINES_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define MPFBA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define MPFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mpfba_pkg.sv
// types and constants shared by the flow byte aggregator modules
package mpfba_pkg;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned BYTE_W = 32;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned STAT_W = 3;

  localparam logic [3:0] IPV4_CODE = 4'd4;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [STAT_W-1:0] ST_MERGED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FLUSHED = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dest_mac;
    logic [3:0]        ip_version;
    logic [BYTE_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  entry_source;
    logic [MAC_W-1:0]  entry_dest;
    logic [CNT_W-1:0]  v4_bytes;
    logic [CNT_W-1:0]  v6_bytes;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [MAC_W-1:0] src;
    logic [MAC_W-1:0] dst;
    logic [CNT_W-1:0] v4;
    logic [CNT_W-1:0] v6;
  } entry_t;

  typedef struct packed {
    logic   we;
    entry_t wdata;
  } mem_wr_t;

endpackage

// File: rtl/core/mpfba_table.sv
// flow table storage: one write port, one registered read port
module mpfba_table import mpfba_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic            clk_i,
  input  mem_wr_t         wr_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mpfba_ctrl.sv
// flow table sequencer: scan, merge, append or drop, and flush
`include "mac_pair_flow_byte_aggregator_defines.svh"

module mpfba_ctrl import mpfba_pkg::*; #(
  parameter int unsigned TableDepth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  req_t                                 req_i,
  output logic                                 done_o,
  output res_t                                 res_o,
  output mem_wr_t                              wr_o,
  output logic [((TableDepth > 1) ? $clog2(TableDepth) : 1)-1:0] waddr_o,
  output logic [((TableDepth > 1) ? $clog2(TableDepth) : 1)-1:0] raddr_o,
  input  entry_t                               rdata_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TableDepth);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] idx_q, idx_d;
  req_t            item_q, item_d;
  logic            done_q, done_d;
  res_t            res_q, res_d;
  logic            at_last;
  logic            hit;
  logic [CNT_W:0]  sum;
  logic [CNT_W-1:0] sat;

  function automatic entry_t new_entry(req_t r);
    entry_t e;
    e.src = r.source_mac;
    e.dst = r.dest_mac;
    e.v4  = (r.ip_version == IPV4_CODE) ? CNT_W'(r.byte_count) : '0;
    e.v6  = (r.ip_version == IPV4_CODE) ? '0 : CNT_W'(r.byte_count);
    return e;
  endfunction

  assign busy    = (state_q != S_IDLE);
  assign at_last = (CntW'(idx_q) == fill_q - CntW'(1));
  assign hit     = (rdata_i.src == item_q.source_mac) && (rdata_i.dst == item_q.dest_mac);
  assign sum     = {1'b0, (item_q.ip_version == IPV4_CODE) ? rdata_i.v4 : rdata_i.v6}
                 + (CNT_W + 1)'(item_q.byte_count);
  assign sat     = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  assign raddr_o = (state_q == S_IDLE) ? '0 : idx_q + IdxW'(1);

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    item_d   = item_q;
    done_d   = 1'b0;
    res_d    = '0;
    wr_o     = '0;
    waddr_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = req_i;
          idx_d  = '0;
          if (req_i.kind == KIND_FLUSH) begin
            if (fill_q == '0) begin
              done_d       = 1'b1;
              res_d.status = ST_EMPTY;
              res_d.last   = 1'b1;
            end else begin
              state_d = S_FLUSH;
            end
          end else if (fill_q == '0) begin
            wr_o.we         = 1'b1;
            wr_o.wdata      = new_entry(req_i);
            fill_d          = CntW'(1);
            done_d          = 1'b1;
            res_d.status    = ST_NEW;
            res_d.occupancy = OCC_W'(1);
            res_d.last      = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_o.we    = 1'b1;
          wr_o.wdata = rdata_i;
          if (item_q.ip_version == IPV4_CODE) begin
            wr_o.wdata.v4 = sat;
          end else begin
            wr_o.wdata.v6 = sat;
          end
          waddr_o         = idx_q;
          done_d          = 1'b1;
          res_d.status    = ST_MERGED;
          res_d.occupancy = OCC_W'(fill_q);
          res_d.last      = 1'b1;
          state_d         = S_IDLE;
        end else if (at_last) begin
          done_d     = 1'b1;
          res_d.last = 1'b1;
          state_d    = S_IDLE;
          if (fill_q != FullCnt) begin
            wr_o.we         = 1'b1;
            wr_o.wdata      = new_entry(item_q);
            waddr_o         = fill_q[IdxW-1:0];
            fill_d          = fill_q + CntW'(1);
            res_d.status    = ST_NEW;
            res_d.occupancy = OCC_W'(fill_q + CntW'(1));
          end else begin
            res_d.status    = ST_DROPPED;
            res_d.occupancy = OCC_W'(fill_q);
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_FLUSH: begin
        done_d             = 1'b1;
        res_d.status       = ST_FLUSHED;
        res_d.entry_source = rdata_i.src;
        res_d.entry_dest   = rdata_i.dst;
        res_d.v4_bytes     = rdata_i.v4;
        res_d.v6_bytes     = rdata_i.v6;
        res_d.occupancy    = OCC_W'(fill_q);
        res_d.last         = at_last;
        if (at_last) begin
          fill_d  = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `MPFBA_ASSERT(fill_in_range_a, 1'b1, fill_q <= FullCnt, "fill count beyond table depth")
  `MPFBA_ASSERT(write_ends_item_a, wr_o.we, state_d == S_IDLE, "table write mid transaction")
  `MPFBA_ASSERT(last_means_idle_a, done_q && res_q.last, state_q == S_IDLE,
    "final result while still busy")
  `MPFBA_ASSERT(more_means_flush_a, done_q && !res_q.last, state_q == S_FLUSH,
    "non-final result outside a flush")
  `MPFBA_ASSERT_NEXT(flush_empties_a, state_q == S_FLUSH && state_d == S_IDLE, fill_q == '0,
    "table not empty after flush")

endmodule

// File: rtl/core/mac_pair_flow_byte_aggregator.sv
// top level of the flow byte aggregator keyed by mac address pairs
//
// usage:
//   a transaction is taken when start is high and busy is low; req_i carries
//   the kind (add or flush), the two mac addresses, the ip version and the
//   byte count. results come on res_o, each marked by done_o for one cycle;
//   the receiver has no way to stall and must take every result.
// operation:
//   an add into an empty table answers in the cycle after start and the block
//   is free again at once. an add into a table of n entries reads one entry
//   per cycle from the table memory (one read port, registered read); busy
//   stays high until its result comes, so no new transaction is taken before
//   then. a flush streams one entry per cycle, the first once the flush state
//   has read and registered it, the final one with last set.
// reset:
//   asynchronous, active low; the table comes up empty, the entry memory
//   itself is not cleared and needs no clearing pass.
module mac_pair_flow_byte_aggregator import mpfba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  mem_wr_t         wr;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  mpfba_ctrl #(
    .TableDepth(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o),
    .wr_o   (wr),
    .waddr_o(waddr),
    .raddr_o(raddr),
    .rdata_i(rdata)
  );

  mpfba_table #(
    .Depth(TABLE_DEPTH),
    .IdxW (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .waddr_i(waddr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

// File: test/testbench.sv
// self-checking testbench for the mac pair flow byte aggregator
`timescale 1ns / 100ps

module testbench;
  import mpfba_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;

  mac_pair_flow_byte_aggregator #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // flow table mirror
  logic [MAC_W-1:0] flow_src[DEPTH];
  logic [MAC_W-1:0] flow_dst[DEPTH];
  logic [CNT_W-1:0] flow_v4[DEPTH];
  logic [CNT_W-1:0] flow_v6[DEPTH];
  int               flow_fill;

  res_t pending_results[$];

  // traffic pool for random transactions
  logic [MAC_W-1:0] pool_src[80];
  logic [MAC_W-1:0] pool_dst[80];

  int  error_count;
  int  cycle_count;
  int  sent_count;
  int  result_count;
  int  merge_count;
  int  drop_count;
  int  flush_count;
  bit  idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** mac_pair_flow_byte_aggregator: FAILED **");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] acc, logic [BYTE_W-1:0] n);
    logic [CNT_W:0] total;
    total = {1'b0, acc} + {{(CNT_W+1-BYTE_W){1'b0}}, n};
    return total[CNT_W] ? {CNT_W{1'b1}} : total[CNT_W-1:0];
  endfunction

  function automatic void predict_flow(req_t r);
    res_t exp;
    int   hit;
    bit   is_v4;
    exp   = '0;
    hit   = -1;
    is_v4 = (r.ip_version == IPV4_CODE);
    if (r.kind == KIND_FLUSH) begin
      flush_count++;
      if (flow_fill == 0) begin
        exp.status = ST_EMPTY;
        exp.last   = 1'b1;
        pending_results.push_back(exp);
      end else begin
        for (int k = 0; k < flow_fill; k++) begin
          exp.status       = ST_FLUSHED;
          exp.entry_source = flow_src[k];
          exp.entry_dest   = flow_dst[k];
          exp.v4_bytes     = flow_v4[k];
          exp.v6_bytes     = flow_v6[k];
          exp.occupancy    = OCC_W'(flow_fill);
          exp.last         = (k == flow_fill - 1);
          pending_results.push_back(exp);
        end
        flow_fill = 0;
      end
      return;
    end
    for (int k = 0; k < flow_fill; k++) begin
      if (hit < 0 && flow_src[k] == r.source_mac && flow_dst[k] == r.dest_mac) hit = k;
    end
    exp.last = 1'b1;
    if (hit >= 0) begin
      if (is_v4) flow_v4[hit] = sat_sum(flow_v4[hit], r.byte_count);
      else flow_v6[hit] = sat_sum(flow_v6[hit], r.byte_count);
      exp.status    = ST_MERGED;
      exp.occupancy = OCC_W'(flow_fill);
      merge_count++;
    end else if (flow_fill < DEPTH) begin
      flow_src[flow_fill] = r.source_mac;
      flow_dst[flow_fill] = r.dest_mac;
      flow_v4[flow_fill]  = is_v4 ? CNT_W'(r.byte_count) : '0;
      flow_v6[flow_fill]  = is_v4 ? '0 : CNT_W'(r.byte_count);
      flow_fill++;
      exp.status    = ST_NEW;
      exp.occupancy = OCC_W'(flow_fill);
    end else begin
      exp.status    = ST_DROPPED;
      exp.occupancy = OCC_W'(flow_fill);
      drop_count++;
    end
    pending_results.push_back(exp);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t exp;
    if (rst_ni && done_o) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d", res_o.status);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        if (res_o.status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, res_o.status);
          error_count++;
        end
        if (res_o.entry_source !== exp.entry_source) begin
          $error("entry_source: expected %h, got %h", exp.entry_source, res_o.entry_source);
          error_count++;
        end
        if (res_o.entry_dest !== exp.entry_dest) begin
          $error("entry_dest: expected %h, got %h", exp.entry_dest, res_o.entry_dest);
          error_count++;
        end
        if (res_o.v4_bytes !== exp.v4_bytes) begin
          $error("v4_bytes: expected %h, got %h", exp.v4_bytes, res_o.v4_bytes);
          error_count++;
        end
        if (res_o.v6_bytes !== exp.v6_bytes) begin
          $error("v6_bytes: expected %h, got %h", exp.v6_bytes, res_o.v6_bytes);
          error_count++;
        end
        if (res_o.occupancy !== exp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp.occupancy, res_o.occupancy);
          error_count++;
        end
        if (res_o.last !== exp.last) begin
          $error("last: expected %0d, got %0d", exp.last, res_o.last);
          error_count++;
        end
      end
    end
  end

  // one transaction, with an optional random gap before it
  task automatic send_item(req_t item);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 24 && gap < 12) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    predict_flow(item);
    sent_count++;
  endtask

  task automatic send_add(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                          logic [3:0] ver, logic [BYTE_W-1:0] nbytes);
    req_t r;
    r.kind       = KIND_ADD;
    r.source_mac = src;
    r.dest_mac   = dst;
    r.ip_version = ver;
    r.byte_count = nbytes;
    send_item(r);
  endtask

  task automatic send_flush();
    req_t         r;
    logic [159:0] raw;
    raw          = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r            = raw[$bits(req_t)-1:0];
    r.kind       = KIND_FLUSH;
    send_item(r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_flush();
    req_t r;
    r      = '1;
    r.kind = KIND_FLUSH;
    send_item(r);
    send_flush();
    wait_drained();
  endtask

  task automatic test_ip_versions();
    logic [MAC_W-1:0] a;
    logic [MAC_W-1:0] b;
    a = rand_mac();
    b = rand_mac();
    send_add(a, b, IPV4_CODE, '1);
    send_add(a, b, 4'd6, 32'd1);
    send_add(a, b, 4'd0, '1);
    send_add(a, b, 4'hf, 32'd0);
    send_add(a, b, IPV4_CODE, '1);
    send_add(b, a, 4'd5, 32'h8000_0000);
    send_flush();
    wait_drained();
  endtask

  task automatic test_mac_extremes();
    send_add('0, '0, IPV4_CODE, 32'd1);
    send_add('1, '1, 4'd6, '1);
    send_add('0, '1, IPV4_CODE, 32'h5555_aaaa);
    send_add('1, '0, 4'd6, 32'haaaa_5555);
    send_add('1, '1, 4'd6, '1);
    send_flush();
    wait_drained();
  endtask

  // pairs that share one address, or differ in a single bit
  task automatic test_near_match();
    logic [MAC_W-1:0] a;
    logic [MAC_W-1:0] b;
    a = rand_mac();
    b = rand_mac();
    send_add(a, b, IPV4_CODE, 32'd100);
    send_add(a, b ^ 48'h1, IPV4_CODE, 32'd200);
    send_add(a ^ (48'h1 << 47), b, 4'd6, 32'd300);
    send_add(b, b, 4'd6, 32'd400);
    send_add(a, b, 4'd6, 32'd500);
    send_flush();
    wait_drained();
  endtask

  // fill every entry, then drop, merge into the last entry and flush all
  task automatic test_table_full();
    logic [MAC_W-1:0] last_src;
    logic [MAC_W-1:0] last_dst;
    for (int k = 0; k < DEPTH; k++) begin
      last_src = {rand_mac()} ^ (MAC_W'(k) << 40);
      last_dst = MAC_W'(k);
      send_add(last_src, last_dst, 4'($urandom), $urandom);
    end
    send_add(rand_mac(), '1, IPV4_CODE, '1);
    send_add(last_src, last_dst, IPV4_CODE, '1);
    send_add(last_src, last_dst, 4'd6, '1);
    send_flush();
    wait_drained();
  endtask

  task automatic test_random_traffic(int count);
    int               sel;
    int               p;
    logic [3:0]       ver;
    logic [BYTE_W-1:0] nbytes;
    for (int k = 0; k < 80; k++) begin
      pool_src[k] = (k % 3 == 0 && k > 0) ? pool_src[0] : rand_mac();
      pool_dst[k] = rand_mac();
    end
    for (int n = 0; n < count; n++) begin
      idle_on = (n >= 100);
      sel     = $urandom_range(99);
      ver     = $urandom_range(1) ? IPV4_CODE : 4'($urandom);
      case ($urandom_range(5))
        0: nbytes = '1;
        1: nbytes = '0;
        2: nbytes = 32'($urandom_range(255));
        default: nbytes = $urandom;
      endcase
      if (sel < 3) begin
        send_flush();
      end else if (sel < 75) begin
        p = $urandom_range(79);
        send_add(pool_src[p], pool_dst[p], ver, nbytes);
      end else begin
        send_add(rand_mac(), rand_mac(), ver, nbytes);
      end
    end
    send_flush();
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    flow_fill    = 0;
    error_count  = 0;
    cycle_count  = 0;
    sent_count   = 0;
    result_count = 0;
    merge_count  = 0;
    drop_count   = 0;
    flush_count  = 0;
    idle_on      = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_flush();
    test_ip_versions();
    test_mac_extremes();
    test_near_match();
    test_table_full();
    test_random_traffic(290);

    repeat (80) @(posedge clk_i);
    $display("run covered %0d transactions and %0d results: %0d merges, %0d drops, %0d flushes",
             sent_count, result_count, merge_count, drop_count, flush_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** mac_pair_flow_byte_aggregator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_results.size());
      $display("** mac_pair_flow_byte_aggregator: FAILED **");
    end
    $finish;
  end

endmodule

// File: mac_pair_flow_byte_aggregator.f
+incdir+rtl/core
rtl/core/mpfba_pkg.sv
rtl/core/mpfba_table.sv
rtl/core/mpfba_ctrl.sv
rtl/core/mac_pair_flow_byte_aggregator.sv
test/testbench.sv
